FILE: hw/rtl/keypad_calculator_controller_macros.svh
// Assertion macros shared by the calculator checker.
`ifndef KEYPAD_CALCULATOR_CONTROLLER_MACROS_SVH
`define KEYPAD_CALCULATOR_CONTROLLER_MACROS_SVH

// Check cons in the same cycle as ante.
`define KCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define KCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kcc_pkg.sv
// Types, constants and lookup functions of the keypad calculator.
package kcc_pkg;

    localparam int DIGITS     = 6;
    localparam int NUM_OUT    = 6;
    localparam int SHOWN      = (DIGITS < NUM_OUT) ? DIGITS : NUM_OUT;
    localparam int SCAN_W     = 8;
    localparam int SEG_W      = 7;
    localparam int OPND_W     = 16;
    localparam int CNT_W      = $clog2(OPND_W);
    localparam int ENTRY_W    = 3;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DD_W       = BCD_W + OPND_W;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = ENTRY_W'(DIGITS - 1);
    localparam logic [SEG_W-1:0]   SEG_ZERO  = 7'h3f;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_ADD       = 4'd10;
    localparam logic [3:0] KEY_DIV       = 4'd13;
    localparam logic [3:0] KEY_EQUALS    = 4'd14;
    localparam logic [3:0] KEY_CLEAR     = 4'd15;

    typedef struct packed {
        logic       none;
        logic [3:0] code;
    } t_key;

    localparam t_key KEY_NONE = '{none: 1'b1, code: 4'hf};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CONV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic conv_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic eq_act;
        logic is_div;
        logic cnt_last;
    } t_status;

    function automatic t_key decode_key(input logic [SCAN_W-1:0] code);
        t_key k;
        k.none = 1'b0;
        k.code = 4'd0;
        unique case (code)
            8'hee: k.code = 4'd7;
            8'hde: k.code = 4'd8;
            8'hbe: k.code = 4'd9;
            8'h7e: k.code = 4'd13;
            8'hed: k.code = 4'd4;
            8'hdd: k.code = 4'd5;
            8'hbd: k.code = 4'd6;
            8'h7d: k.code = 4'd12;
            8'heb: k.code = 4'd1;
            8'hdb: k.code = 4'd2;
            8'hbb: k.code = 4'd3;
            8'h7b: k.code = 4'd11;
            8'he7: k.code = 4'd15;
            8'hd7: k.code = 4'd0;
            8'hb7: k.code = 4'd14;
            8'h77: k.code = 4'd10;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] sym);
        logic [SEG_W-1:0] s;
        unique case (sym)
            4'd0:  s = 7'h3f;
            4'd1:  s = 7'h06;
            4'd2:  s = 7'h5b;
            4'd3:  s = 7'h4f;
            4'd4:  s = 7'h66;
            4'd5:  s = 7'h6d;
            4'd6:  s = 7'h7d;
            4'd7:  s = 7'h07;
            4'd8:  s = 7'h7f;
            4'd9:  s = 7'h6f;
            4'd10: s = 7'h77;
            4'd11: s = 7'h7c;
            4'd12: s = 7'h39;
            4'd13: s = 7'h5e;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/kcc_in_if.sv
// Keypad scan code channel.
interface kcc_in_if;
    logic                      valid;
    logic                      ready;
    logic [kcc_pkg::SCAN_W-1:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

FILE: hw/rtl/kcc_out_if.sv
// Display contents channel.
interface kcc_out_if;
    logic                     valid;
    logic                     ready;
    logic [kcc_pkg::SEG_W-1:0] digit0;
    logic [kcc_pkg::SEG_W-1:0] digit1;
    logic [kcc_pkg::SEG_W-1:0] digit2;
    logic [kcc_pkg::SEG_W-1:0] digit3;
    logic [kcc_pkg::SEG_W-1:0] digit4;
    logic [kcc_pkg::SEG_W-1:0] digit5;

    modport source (output valid, output digit0, output digit1, output digit2,
                    output digit3, output digit4, output digit5, input ready);
    modport sink   (input valid, input digit0, input digit1, input digit2,
                    input digit3, input digit4, input digit5, output ready);
endinterface

FILE: hw/rtl/keypad_calculator_controller.sv
// Top level of the keypad four-function calculator.
//
//   channel  dir  payload                      beat taken when
//   i_in     in   scan_code[7:0]               valid & ready
//   o_out    out  digit0..digit5 [6:0] each    valid & ready
//
// A key that only updates operands or the display goes from S_IDLE through S_EMIT to its beat.
// Equals runs one shared counter: 16 restoring divide steps (divide only) and
// 16 double-dabble steps, then leaves its beat through S_EMIT.
// A new beat is taken while the previous result still waits in o_out.
// A stalled o_out holds the block in its last step until the sink takes it.
// Reset is synchronous; the display then shows 0 at the rightmost position.
module keypad_calculator_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kcc_in_if.sink     i_in,
    kcc_out_if.source  o_out
);

    kcc_pkg::t_cmd           cmd;
    kcc_pkg::t_status        status;
    logic [kcc_pkg::SEG_W-1:0] digits [kcc_pkg::NUM_OUT];

    kcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kcc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scan_code (i_in.scan_code),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_digits    (digits)
    );

    assign o_out.digit0 = digits[0];
    assign o_out.digit1 = digits[1];
    assign o_out.digit2 = digits[2];
    assign o_out.digit3 = digits[3];
    assign o_out.digit4 = digits[4];
    assign o_out.digit5 = digits[5];

endmodule

FILE: hw/rtl/kcc_ctrl.sv
// Sequencing state machine of the keypad calculator.
module kcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  kcc_pkg::t_status  i_status,
    output kcc_pkg::t_cmd     o_cmd
);

    kcc_pkg::t_state r_state;
    kcc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kcc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_status.eq_act) begin
                        n_state = kcc_pkg::S_EMIT;
                    end else if (i_status.is_div) begin
                        n_state = kcc_pkg::S_DIV;
                    end else begin
                        n_state = kcc_pkg::S_CONV;
                    end
                end
            end
            kcc_pkg::S_DIV: begin
                if (i_status.cnt_last) begin
                    n_state = kcc_pkg::S_CONV;
                end
            end
            kcc_pkg::S_CONV: begin
                if (i_status.cnt_last) begin
                    n_state = kcc_pkg::S_EMIT;
                end
            end
            kcc_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = kcc_pkg::S_IDLE;
                end
            end
            default: n_state = kcc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            kcc_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            kcc_pkg::S_DIV:  o_cmd.div_step  = 1'b1;
            kcc_pkg::S_CONV: o_cmd.conv_step = 1'b1;
            kcc_pkg::S_EMIT: o_cmd.emit      = out_free;
            default: o_cmd = '0;
        endcase
    end

    // Hold the result beat until the sink takes it.
    assign n_out_valid = o_cmd.emit || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kcc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/kcc_dpath.sv
// Operand, display, divider and decimal conversion datapath.
module kcc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [kcc_pkg::SCAN_W-1:0]  i_scan_code,
    input  kcc_pkg::t_cmd               i_cmd,
    output kcc_pkg::t_status            o_status,
    output logic [kcc_pkg::SEG_W-1:0]   o_digits [kcc_pkg::NUM_OUT]
);

    // Add 3 to every decimal digit of 5 or more, then shift in one binary bit.
    function automatic logic [kcc_pkg::DD_W-1:0] dabble(
        input logic [kcc_pkg::DD_W-1:0] v
    );
        logic [kcc_pkg::DD_W-1:0] a;
        a = v;
        for (int d = 0; d < kcc_pkg::BCD_DIGITS; d++) begin
            if (a[kcc_pkg::OPND_W + 4*d +: 4] >= 4'd5) begin
                a[kcc_pkg::OPND_W + 4*d +: 4] = a[kcc_pkg::OPND_W + 4*d +: 4] + 4'd3;
            end
        end
        return {a[kcc_pkg::DD_W-2:0], 1'b0};
    endfunction

    logic [kcc_pkg::OPND_W-1:0]  r_first;
    logic [kcc_pkg::OPND_W-1:0]  r_second;
    kcc_pkg::t_op                r_op;
    logic                        r_phase;
    logic [kcc_pkg::ENTRY_W-1:0] r_entry;
    kcc_pkg::t_key               r_prev;
    logic [kcc_pkg::SEG_W-1:0]   r_disp [kcc_pkg::DIGITS];

    logic [kcc_pkg::OPND_W-1:0]  r_rem;
    logic [kcc_pkg::OPND_W-1:0]  r_quo;
    logic [kcc_pkg::OPND_W-1:0]  r_dvs;
    logic [kcc_pkg::CNT_W-1:0]   r_cnt;
    logic [kcc_pkg::DD_W-1:0]    r_dd;
    logic [kcc_pkg::SEG_W-1:0]   r_out [kcc_pkg::NUM_OUT];

    kcc_pkg::t_key               key;
    logic                        key_new;
    logic                        is_digit;
    logic                        is_op;
    logic                        is_clear;
    logic                        eq_act;
    logic [kcc_pkg::OPND_W-1:0]  cur;
    logic [kcc_pkg::OPND_W+3:0]  acc;
    logic [kcc_pkg::ENTRY_W-1:0] n_entry;
    logic [kcc_pkg::SEG_W-1:0]   shift_disp [kcc_pkg::DIGITS];
    logic [kcc_pkg::SEG_W-1:0]   result_disp [kcc_pkg::DIGITS];
    logic [kcc_pkg::OPND_W-1:0]  alu;
    logic [kcc_pkg::OPND_W:0]    rem_sh;
    logic [kcc_pkg::OPND_W:0]    rem_diff;
    logic [kcc_pkg::OPND_W-1:0]  n_rem;
    logic [kcc_pkg::OPND_W-1:0]  n_quo;
    logic [kcc_pkg::DD_W-1:0]    n_dd;
    logic [kcc_pkg::BCD_W-1:0]   bcd;

    assign key      = kcc_pkg::decode_key(i_scan_code);
    assign key_new  = key != r_prev;
    assign is_digit = !key.none && key.code <= kcc_pkg::KEY_DIGIT_MAX;
    assign is_op    = !key.none && key.code >= kcc_pkg::KEY_ADD
                      && key.code <= kcc_pkg::KEY_DIV && !r_phase;
    assign is_clear = !key.none && key.code == kcc_pkg::KEY_CLEAR;
    assign eq_act   = key_new && !key.none && key.code == kcc_pkg::KEY_EQUALS && r_phase;

    assign o_status.eq_act   = eq_act;
    assign o_status.is_div   = r_op == kcc_pkg::OP_DIV;
    assign o_status.cnt_last = &r_cnt;

    // Operand times ten plus the new digit, wrapping at 16 bits.
    assign cur = r_phase ? r_second : r_first;
    assign acc = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0}
                 + {{kcc_pkg::OPND_W{1'b0}}, key.code};
    assign n_entry = (r_entry < kcc_pkg::ENTRY_MAX) ? r_entry + 1'b1 : r_entry;

    always_comb begin
        for (int j = 0; j < kcc_pkg::DIGITS; j++) begin
            shift_disp[j] = r_disp[j];
        end
        for (int j = 1; j < kcc_pkg::DIGITS; j++) begin
            if (kcc_pkg::ENTRY_W'(j) <= r_entry) begin
                shift_disp[j] = r_disp[j-1];
            end
        end
        shift_disp[0] = kcc_pkg::seg_pattern(key.code);
    end

    always_comb begin
        case (r_op)
            kcc_pkg::OP_ADD: alu = r_first + r_second;
            kcc_pkg::OP_SUB: alu = r_first - r_second;
            kcc_pkg::OP_MUL: alu = kcc_pkg::OPND_W'(r_first * r_second);
            default:         alu = '0;
        endcase
    end

    // Restoring divide step; a zero divisor leaves an all-ones quotient.
    assign rem_sh   = {r_rem, r_quo[kcc_pkg::OPND_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign n_rem    = rem_diff[kcc_pkg::OPND_W] ? rem_sh[kcc_pkg::OPND_W-1:0]
                                                : rem_diff[kcc_pkg::OPND_W-1:0];
    assign n_quo    = {r_quo[kcc_pkg::OPND_W-2:0], !rem_diff[kcc_pkg::OPND_W]};

    assign n_dd = dabble(r_dd);
    assign bcd  = n_dd[kcc_pkg::DD_W-1:kcc_pkg::OPND_W];

    // Blank every position above the most significant nonzero digit.
    always_comb begin
        for (int k = 0; k < kcc_pkg::DIGITS; k++) begin
            result_disp[k] = '0;
        end
        for (int k = 0; k < kcc_pkg::BCD_DIGITS; k++) begin
            if (k == 0 || (bcd >> (4*k)) != '0) begin
                result_disp[k] = kcc_pkg::seg_pattern(bcd[4*k +: 4]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
            r_op     <= kcc_pkg::OP_ADD;
            r_phase  <= 1'b0;
            r_entry  <= '0;
            r_prev   <= '0;
            for (int j = 0; j < kcc_pkg::DIGITS; j++) begin
                r_disp[j] <= (j == 0) ? kcc_pkg::SEG_ZERO : '0;
            end
        end else begin
            if (i_cmd.accept && key_new) begin
                r_prev <= key;
                if (is_digit) begin
                    if (r_phase) begin
                        r_second <= acc[kcc_pkg::OPND_W-1:0];
                    end else begin
                        r_first <= acc[kcc_pkg::OPND_W-1:0];
                    end
                    r_disp  <= shift_disp;
                    r_entry <= n_entry;
                end else if (is_op) begin
                    r_op    <= kcc_pkg::t_op'(2'(key.code - kcc_pkg::KEY_ADD));
                    r_disp  <= shift_disp;
                    r_entry <= n_entry;
                    r_phase <= 1'b1;
                end else if (eq_act) begin
                    r_first  <= '0;
                    r_second <= '0;
                    r_phase  <= 1'b0;
                    r_entry  <= '0;
                end else if (is_clear) begin
                    r_first  <= '0;
                    r_second <= '0;
                    r_phase  <= 1'b0;
                    r_entry  <= '0;
                    for (int j = 0; j < kcc_pkg::DIGITS; j++) begin
                        r_disp[j] <= (j == 0) ? kcc_pkg::SEG_ZERO : '0;
                    end
                end
            end
            if (i_cmd.conv_step && o_status.cnt_last) begin
                r_disp <= result_disp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && eq_act) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= r_first;
            r_dvs <= r_second;
            r_dd  <= {{kcc_pkg::BCD_W{1'b0}}, alu};
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (o_status.cnt_last) begin
                r_dd <= {{kcc_pkg::BCD_W{1'b0}}, n_quo};
            end
        end
        if (i_cmd.conv_step) begin
            r_cnt <= r_cnt + 1'b1;
            r_dd  <= n_dd;
        end
        if (i_cmd.emit) begin
            for (int j = 0; j < kcc_pkg::NUM_OUT; j++) begin
                if (j < kcc_pkg::SHOWN) begin
                    r_out[j] <= r_disp[j];
                end else begin
                    r_out[j] <= '0;
                end
            end
        end
    end

    assign o_digits = r_out;

endmodule

FILE: hw/rtl/kcc_checker.sv
// Port checker of the keypad calculator and its bind.
`include "keypad_calculator_controller_macros.svh"

module kcc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [kcc_pkg::SEG_W-1:0] i_digit0,
    input logic [kcc_pkg::SEG_W-1:0] i_digit5
);

    `KCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_digit0) && $stable(i_digit5), "stalled display beat changed")
    `KCC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "scan beat taken while the previous one is still in work")
    `KCC_ASSERT_SAME(a_right_lit, i_clk, i_rst_n, i_out_valid, i_digit0 != '0, "rightmost display position is blank")

endmodule

bind keypad_calculator_controller kcc_checker u_kcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_digit0    (o_out.digit0),
    .i_digit5    (o_out.digit5)
);

FILE: sim/testbench.sv
// Self-checking testbench for the keypad calculator: keypad polls in, display snapshots checked.
`timescale 1ns / 1ps

module testbench;
    import kcc_pkg::*;

    typedef logic [NUM_OUT-1:0][SEG_W-1:0] t_disp;

    typedef struct {
        logic [SCAN_W-1:0] scan;
        bit                drain;
    } t_poll;

    localparam logic [3:0] KEY_SUB = KEY_ADD + 4'd1;
    localparam logic [3:0] KEY_MUL = KEY_ADD + 4'd2;

    // Scan code of each key, indexed by key code.
    localparam logic [15:0][SCAN_W-1:0] SCAN_OF = {
        8'he7, 8'hb7, 8'h7e, 8'h7d, 8'h7b, 8'h77, 8'hbe, 8'hde,
        8'hee, 8'hbd, 8'hdd, 8'hed, 8'hbb, 8'hdb, 8'heb, 8'hd7
    };
    // Segment pattern of each symbol: digits, then the four operators.
    localparam logic [13:0][SEG_W-1:0] SEG_OF = {
        7'h5e, 7'h39, 7'h7c, 7'h77, 7'h6f, 7'h7f, 7'h07,
        7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
    };

    localparam int LONG_STALL_AT  = 200;
    localparam int LONG_STALL_LEN = 400;
    localparam int POLL_COUNT     = 500;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kcc_in_if  scan_if ();
    kcc_out_if disp_if ();

    keypad_calculator_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (scan_if),
        .o_out   (disp_if)
    );

    always #4 i_clk = ~i_clk;

    // Calculator state as the predictor sees it.
    logic [OPND_W-1:0]  acc_a, acc_b;
    t_op                cur_op;
    logic               in_second;
    logic [ENTRY_W-1:0] entries;
    t_key               last_key;
    logic [SEG_W-1:0]   shown [DIGITS];

    t_poll  poll_q [$];
    t_disp  display_q [$];
    t_key   staged_key;
    bit     drain_next;
    int     sent_cnt, got_cnt, err_cnt;
    int     gap_left, stall_left;
    bit     long_stall_done;

    function automatic t_key key_of(input logic [SCAN_W-1:0] scan);
        t_key k;
        k = KEY_NONE;
        for (int i = 0; i < 16; i++) begin
            if (SCAN_OF[i] == scan) begin
                k.none = 1'b0;
                k.code = 4'(i);
            end
        end
        return k;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void reset_entry();
        acc_a     = '0;
        acc_b     = '0;
        in_second = 1'b0;
        entries   = '0;
    endfunction

    function automatic void shift_symbol(input logic [3:0] sym);
        int top;
        top = (entries > ENTRY_MAX) ? int'(ENTRY_MAX) : int'(entries);
        for (int i = top; i > 0; i--)
            shown[i] = shown[i-1];
        shown[0] = SEG_OF[sym];
        if (entries < ENTRY_MAX)
            entries = entries + 1'b1;
    endfunction

    // Advance the calculator by one poll and return the display it leaves.
    function automatic t_disp press_scan(input logic [SCAN_W-1:0] scan);
        t_key              k;
        logic [OPND_W-1:0] r;
        int                v, pos;
        t_disp             d;
        k = key_of(scan);
        if (k != last_key) begin
            if (!k.none && k.code <= KEY_DIGIT_MAX) begin
                if (!in_second)
                    acc_a = acc_a * 16'd10 + OPND_W'(k.code);
                else
                    acc_b = acc_b * 16'd10 + OPND_W'(k.code);
                shift_symbol(k.code);
            end else if (!k.none && k.code >= KEY_ADD && k.code <= KEY_DIV && !in_second) begin
                cur_op = t_op'(2'(k.code - KEY_ADD));
                shift_symbol(k.code);
                in_second = 1'b1;
            end else if (!k.none && k.code == KEY_EQUALS && in_second) begin
                case (cur_op)
                    OP_ADD:  r = acc_a + acc_b;
                    OP_SUB:  r = acc_a - acc_b;
                    OP_MUL:  r = acc_a * acc_b;
                    default: r = (acc_b == '0) ? '1 : acc_a / acc_b;
                endcase
                foreach (shown[i])
                    shown[i] = '0;
                v   = int'(r);
                pos = 0;
                do begin
                    if (pos < DIGITS)
                        shown[pos] = SEG_OF[v % 10];
                    v = v / 10;
                    pos++;
                end while (v != 0);
                reset_entry();
            end else if (!k.none && k.code == KEY_CLEAR) begin
                reset_entry();
                foreach (shown[i])
                    shown[i] = '0;
                shown[0] = SEG_ZERO;
            end
            last_key = k;
        end
        for (int j = 0; j < NUM_OUT; j++)
            d[j] = (j < DIGITS) ? shown[j] : '0;
        return d;
    endfunction

    function automatic logic [SCAN_W-1:0] release_code();
        logic [SCAN_W-1:0] c;
        if ($urandom_range(0, 1) == 0)
            return '0;
        do
            c = SCAN_W'($urandom_range(0, 255));
        while (key_of(c) != KEY_NONE);
        return c;
    endfunction

    task automatic stage_scan(input logic [SCAN_W-1:0] scan);
        t_poll p;
        p.scan     = scan;
        p.drain    = drain_next;
        drain_next = 1'b0;
        poll_q.push_back(p);
        staged_key = key_of(scan);
    endtask

    // Press a key so that it acts: release first if it repeats the last poll.
    task automatic stage_key(input logic [3:0] code);
        if (!staged_key.none && staged_key.code == code)
            stage_scan(release_code());
        stage_scan(SCAN_OF[code]);
        if ($urandom_range(0, 3) == 0)
            stage_scan(release_code());
    endtask

    task automatic stage_operand(input logic [3:0] op_key);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
        if (op_key == KEY_DIV && $urandom_range(0, 3) == 0)
            stage_key(4'd0);
        else
            repeat (n) stage_key(4'($urandom_range(0, 9)));
    endtask

    task automatic stage_calc();
        logic [3:0] op_key;
        if ($urandom_range(0, 3) == 0)
            stage_key(KEY_CLEAR);
        op_key = KEY_ADD + 4'($urandom_range(0, 3));
        stage_operand(op_key);
        stage_key(op_key);
        // an operator in the second phase is dropped
        if ($urandom_range(0, 9) == 0)
            stage_key(KEY_ADD + 4'($urandom_range(0, 3)));
        stage_operand(op_key);
        if ($urandom_range(0, 15) != 0)
            stage_key(KEY_EQUALS);
    endtask

    // Sender: offer queued polls, hold until taken, gap at random.
    always @(posedge i_clk) begin : driver
        bit accepted;
        accepted = scan_if.valid && scan_if.ready;
        if (!i_rst_n) begin
            scan_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (accepted)
                sent_cnt <= sent_cnt + 1;
            if (scan_if.valid && !accepted) begin
                // hold the beat
            end else if (gap_left > 0) begin
                gap_left--;
                scan_if.valid <= 1'b0;
            end else if (poll_q.size() > 0 &&
                         (!poll_q[0].drain || sent_cnt + int'(accepted) == got_cnt)) begin
                scan_if.valid     <= 1'b1;
                scan_if.scan_code <= poll_q[0].scan;
                void'(poll_q.pop_front());
                gap_left = sent_cnt[6] ? 0 : idle_len();
            end else begin
                scan_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each display beat, then predict from the poll taken.
    always @(posedge i_clk) begin : monitor
        t_disp want, got;
        if (!i_rst_n) begin
            disp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (disp_if.valid && disp_if.ready) begin
                got = {disp_if.digit5, disp_if.digit4, disp_if.digit3,
                       disp_if.digit2, disp_if.digit1, disp_if.digit0};
                if (display_q.size() == 0) begin
                    $error("display beat with no poll waiting: %h", got);
                    err_cnt++;
                end else begin
                    want = display_q.pop_front();
                    for (int j = 0; j < NUM_OUT; j++) begin
                        if (got[j] !== want[j]) begin
                            $error("digit%0d: expected %h, actual %h", j, want[j], got[j]);
                            err_cnt++;
                        end
                    end
                end
                got_cnt <= got_cnt + 1;
            end
            if (scan_if.valid && scan_if.ready)
                display_q.push_back(press_scan(scan_if.scan_code));
            // one long hold-off so the block fills and stalls its input
            if (got_cnt == LONG_STALL_AT && !long_stall_done) begin
                stall_left      = LONG_STALL_LEN;
                long_stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                disp_if.ready <= 1'b0;
            end else begin
                disp_if.ready <= 1'b1;
                stall_left = got_cnt[5] ? 0 : idle_len();
            end
        end
    end

    initial begin : stimulus
        i_rst_n           = 1'b0;
        scan_if.valid     = 1'b0;
        scan_if.scan_code = '0;
        disp_if.ready     = 1'b0;
        sent_cnt          = 0;
        got_cnt           = 0;
        err_cnt           = 0;
        long_stall_done   = 1'b0;
        drain_next        = 1'b0;

        reset_entry();
        cur_op   = OP_ADD;
        last_key = '{none: 1'b0, code: 4'd0};
        foreach (shown[i])
            shown[i] = '0;
        shown[0]   = SEG_ZERO;
        staged_key = last_key;

        // Directed: zero right after reset repeats, no-key codes, early equals.
        stage_scan(SCAN_OF[0]);
        stage_scan(8'h00);
        stage_scan(SCAN_OF[KEY_EQUALS]);
        // Seven digits: entry count saturates and the operand wraps.
        for (int i = 1; i <= 7; i++)
            stage_scan(SCAN_OF[i]);
        stage_scan(SCAN_OF[KEY_MUL]);
        stage_scan(SCAN_OF[KEY_SUB]);
        stage_scan(SCAN_OF[8]);
        stage_scan(SCAN_OF[8]);
        stage_scan(SCAN_OF[9]);
        stage_scan(SCAN_OF[KEY_EQUALS]);
        // Divide by zero, then a digit over the left-over result digits.
        stage_scan(SCAN_OF[KEY_DIV]);
        stage_scan(SCAN_OF[KEY_EQUALS]);
        stage_scan(SCAN_OF[0]);
        stage_scan(SCAN_OF[KEY_ADD]);
        stage_scan(8'hff);
        stage_scan(SCAN_OF[9]);
        stage_scan(SCAN_OF[KEY_EQUALS]);
        // Clear, then subtract below zero.
        stage_scan(SCAN_OF[KEY_CLEAR]);
        stage_scan(SCAN_OF[KEY_SUB]);
        stage_scan(SCAN_OF[1]);
        stage_scan(SCAN_OF[KEY_EQUALS]);

        drain_next = 1'b1;
        while (poll_q.size() < POLL_COUNT) begin
            if (poll_q.size() > POLL_COUNT / 2 && poll_q.size() < POLL_COUNT / 2 + 8)
                drain_next = 1'b1;
            if ($urandom_range(0, 4) != 0) begin
                stage_calc();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 2) == 0)
                        stage_scan(SCAN_OF[$urandom_range(0, 15)]);
                    else
                        stage_scan(SCAN_W'($urandom_range(0, 255)));
                end
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (poll_q.size() > 0 || scan_if.valid || sent_cnt != got_cnt)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (err_cnt == 0 && display_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
